>>> design/cmp_pkg.sv
// Package for the complex magnitude and phase core.
// Holds the fixed formats, result limits and the arctangent table of the CORDIC.
// No dependencies.
package cmp_pkg;

  localparam int MAG_W = 16;
  localparam int PHASE_W = 16;
  localparam int GUARD_BITS = 24;
  localparam int ANGLE_W = 26;
  localparam int ANGLE_TABLE_SIZE = 24;
  localparam int PHASE_SHIFT = 9;

  localparam logic [MAG_W-1:0] MAG_MAX = 16'hFFFF;
  localparam logic signed [ANGLE_W-1:0] DEG180 = 26'sd11796480;
  localparam logic signed [ANGLE_W-1:0] PHASE_ROUND = 26'sd256;
  localparam logic signed [ANGLE_W-1:0] PHASE_LIMIT = 26'sd23040;

  function automatic logic signed [ANGLE_W-1:0] atan_q16(input int unsigned idx);
    logic signed [ANGLE_W-1:0] val;
    case (idx)
      0:  val = 26'sd2949120;
      1:  val = 26'sd1740967;
      2:  val = 26'sd919879;
      3:  val = 26'sd466945;
      4:  val = 26'sd234379;
      5:  val = 26'sd117304;
      6:  val = 26'sd58666;
      7:  val = 26'sd29335;
      8:  val = 26'sd14668;
      9:  val = 26'sd7334;
      10: val = 26'sd3667;
      11: val = 26'sd1833;
      12: val = 26'sd917;
      13: val = 26'sd458;
      14: val = 26'sd229;
      15: val = 26'sd115;
      16: val = 26'sd57;
      17: val = 26'sd29;
      18: val = 26'sd14;
      19: val = 26'sd7;
      20: val = 26'sd4;
      21: val = 26'sd2;
      22: val = 26'sd1;
      default: val = '0;
    endcase
    return val;
  endfunction

endpackage

>>> design/cmp_if.sv
// Valid/ready channel interfaces of the complex magnitude and phase core.
// Depends on cmp_pkg for the result field widths.
interface cmp_in_if #(
  parameter int PART_WIDTH = 16
);
  logic                         valid;
  logic                         ready;
  logic signed [PART_WIDTH-1:0] real_part;
  logic signed [PART_WIDTH-1:0] imag_part;

  modport source (output valid, real_part, imag_part, input ready);
  modport sink   (input valid, real_part, imag_part, output ready);
endinterface

interface cmp_out_if;
  import cmp_pkg::*;
  logic                      valid;
  logic                      ready;
  logic        [MAG_W-1:0]   magnitude;
  logic signed [PHASE_W-1:0] phase_degrees;

  modport source (output valid, magnitude, phase_degrees, input ready);
  modport sink   (input valid, magnitude, phase_degrees, output ready);
endinterface

>>> design/complex_magnitude_phase_core.sv
// Rectangular-to-polar converter: rounded magnitude by a pipelined integer square root,
// four-quadrant phase by an unrolled vectoring CORDIC.
// Depends on cmp_pkg and the channel interfaces in cmp_if.sv.
//
//  channel | dir | payload                        | transaction
//  in_i    | in  | real_part, imag_part           | valid && ready
//  out_o   | out | magnitude, phase_degrees       | valid && ready
//
// There is one stage per CORDIC micro-rotation and per root bit, plus setup, square,
// sum and output stages. One transaction per cycle is accepted while in_i.ready is high;
// ready falls only when the output stalls and every stage is full. Each stage holds its
// own valid bit and advances when the stage after it is empty or advancing, so bubbles
// collapse under a stall. Reset clears the valid bits only.
module complex_magnitude_phase_core #(
  parameter int ITERATIONS = 16,
  parameter int PART_WIDTH = 16
) (
  input  logic     clk_i,
  input  logic     rst_ni,
  cmp_in_if.sink   in_i,
  cmp_out_if.source out_o
);
  import cmp_pkg::*;

  localparam int PW = PART_WIDTH;
  localparam int NW = 2 * PART_WIDTH;
  localparam int XW = PART_WIDTH + GUARD_BITS + 3;
  localparam int S  = (ITERATIONS > PART_WIDTH) ? ITERATIONS : PART_WIDTH;
  localparam int NS = S + 3;
  localparam int RW = PART_WIDTH + 1;

  typedef struct packed {
    logic signed [XW-1:0]      x;
    logic signed [XW-1:0]      y;
    logic signed [ANGLE_W-1:0] z;
    logic                      zero;
    logic [PW-1:0]             ar;
    logic [PW-1:0]             ai;
    logic [NW-1:0]             sa;
    logic [NW-1:0]             sb;
    logic [NW-1:0]             n;
    logic [PW+1:0]             rem;
    logic [PW-1:0]             root;
  } stage_t;

  stage_t st_q [NS];
  stage_t st_d [NS];
  logic [NS-1:0] v_q;
  logic [NS:0]   rdy;

  logic                      out_v_q;
  logic [MAG_W-1:0]          mag_q, mag_d;
  logic signed [PHASE_W-1:0] phase_q, phase_d;

  logic [PW-1:0]        re_u, im_u;
  logic signed [XW-1:0] re_x, im_x;

  assign re_u = in_i.real_part;
  assign im_u = in_i.imag_part;
  assign re_x = {{(XW-PW-GUARD_BITS){re_u[PW-1]}}, re_u, {GUARD_BITS{1'b0}}};
  assign im_x = {{(XW-PW-GUARD_BITS){im_u[PW-1]}}, im_u, {GUARD_BITS{1'b0}}};

  // handshake chain
  always_comb begin
    logic chain;
    chain   = !out_v_q || out_o.ready;
    rdy[NS] = chain;
    for (int s = NS - 1; s >= 0; s--) begin
      chain  = !v_q[s] || chain;
      rdy[s] = chain;
    end
  end
  assign in_i.ready = rdy[0];

  // setup: magnitudes of the parts, quadrant pre-rotation
  always_comb begin
    st_d[0]      = '0;
    st_d[0].zero = (re_u == '0) && (im_u == '0);
    st_d[0].ar   = re_u[PW-1] ? (~re_u + PW'(1)) : re_u;
    st_d[0].ai   = im_u[PW-1] ? (~im_u + PW'(1)) : im_u;
    if (re_u[PW-1]) begin
      st_d[0].x = -re_x;
      st_d[0].y = -im_x;
      st_d[0].z = im_u[PW-1] ? -DEG180 : DEG180;
    end else begin
      st_d[0].x = re_x;
      st_d[0].y = im_x;
      st_d[0].z = '0;
    end
  end

  // squares
  always_comb begin
    st_d[1]    = st_q[0];
    st_d[1].sa = NW'(st_q[0].ar) * NW'(st_q[0].ar);
    st_d[1].sb = NW'(st_q[0].ai) * NW'(st_q[0].ai);
  end

  // sum of squares, root start
  always_comb begin
    st_d[2]      = st_q[1];
    st_d[2].n    = st_q[1].sa + st_q[1].sb;
    st_d[2].rem  = '0;
    st_d[2].root = '0;
  end

  // at most one micro-rotation and one root bit per stage
  for (genvar k = 0; k < S; k++) begin : g_core
    localparam int SI = k + 3;
    logic [PW+3:0]        rem_sh, trial;
    logic signed [XW-1:0] dx, dy;

    always_comb begin
      st_d[SI] = st_q[SI-1];
      rem_sh   = {st_q[SI-1].rem, st_q[SI-1].n[NW-1 -: 2]};
      trial    = (PW+4)'({st_q[SI-1].root, 2'b01});
      dx       = st_q[SI-1].x >>> k;
      dy       = st_q[SI-1].y >>> k;
      if (k < PART_WIDTH) begin
        st_d[SI].n = st_q[SI-1].n << 2;
        if (rem_sh >= trial) begin
          st_d[SI].rem  = (PW+2)'(rem_sh - trial);
          st_d[SI].root = {st_q[SI-1].root[PW-2:0], 1'b1};
        end else begin
          st_d[SI].rem  = (PW+2)'(rem_sh);
          st_d[SI].root = {st_q[SI-1].root[PW-2:0], 1'b0};
        end
      end
      if (k < ITERATIONS) begin
        if (!st_q[SI-1].y[XW-1]) begin
          st_d[SI].x = st_q[SI-1].x + dy;
          st_d[SI].y = st_q[SI-1].y - dx;
          st_d[SI].z = st_q[SI-1].z + atan_q16(k);
        end else begin
          st_d[SI].x = st_q[SI-1].x - dy;
          st_d[SI].y = st_q[SI-1].y + dx;
          st_d[SI].z = st_q[SI-1].z - atan_q16(k);
        end
      end
    end
  end

  // stage registers
  for (genvar s = 0; s < NS; s++) begin : g_stage
    logic v_in;
    if (s == 0) begin : g_first
      assign v_in = in_i.valid;
    end else begin : g_next
      assign v_in = v_q[s-1];
    end

    always_ff @(posedge clk_i or negedge rst_ni) begin
      if (!rst_ni) begin
        v_q[s] <= 1'b0;
      end else if (rdy[s]) begin
        v_q[s] <= v_in;
      end
    end

    always_ff @(posedge clk_i) begin
      if (rdy[s] && v_in) begin
        st_q[s] <= st_d[s];
      end
    end
  end

  // round and saturate
  logic [RW-1:0]             mag_r;
  logic [RW+MAG_W-1:0]       mag_w;
  logic signed [ANGLE_W-1:0] ph_z;

  always_comb begin
    mag_r = {1'b0, st_q[NS-1].root}
          + RW'(st_q[NS-1].rem > (PW+2)'(st_q[NS-1].root));
    mag_w = (RW+MAG_W)'(mag_r);
    mag_d = (mag_w > (RW+MAG_W)'(MAG_MAX)) ? MAG_MAX : mag_w[MAG_W-1:0];
    ph_z  = (st_q[NS-1].z + PHASE_ROUND) >>> PHASE_SHIFT;
    if (st_q[NS-1].zero) begin
      phase_d = '0;
    end else if (ph_z > PHASE_LIMIT) begin
      phase_d = PHASE_LIMIT[PHASE_W-1:0];
    end else if (ph_z < -PHASE_LIMIT) begin
      phase_d = PHASE_W'(-PHASE_LIMIT);
    end else begin
      phase_d = ph_z[PHASE_W-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q <= 1'b0;
    end else if (rdy[NS]) begin
      out_v_q <= v_q[NS-1];
    end
  end

  always_ff @(posedge clk_i) begin
    if (rdy[NS] && v_q[NS-1]) begin
      mag_q   <= mag_d;
      phase_q <= phase_d;
    end
  end

  assign out_o.valid         = out_v_q;
  assign out_o.magnitude     = mag_q;
  assign out_o.phase_degrees = phase_q;

endmodule
